FILE: design/ppgd_pkg.sv
// shared types, constants and helpers for the pedal pulse gesture detector
package ppgd_pkg;

  // field widths
  localparam int unsigned LevelW = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PhaseW = 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DETECT_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_THR    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_DELAY  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAP_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RISE_DEADLN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RISE_DEBNC  = 3'd5;

  // register reset values
  localparam logic [LevelW-1:0] DetectThrRst  = 10'd100;
  localparam logic [LevelW-1:0] TrimThrRst    = 10'd900;
  localparam logic [MsW-1:0]    HoldDelayRst  = 16'd200;
  localparam logic [MsW-1:0]    GapTimeoutRst = 16'd200;
  localparam logic [MsW-1:0]    RiseDeadlnRst = 16'd200;
  localparam logic [MsW-1:0]    RiseDebncRst  = 16'd0;

  // reported phase codes
  localparam logic [PhaseW-1:0] PHASE_IDLE   = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_FIRST  = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_GAP    = 2'd2;
  localparam logic [PhaseW-1:0] PHASE_SECOND = 2'd3;

  // gesture state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIRST  = 4'b0010,
    ST_GAP    = 4'b0100,
    ST_SECOND = 4'b1000
  } ppgd_state_e;

  typedef struct packed {
    logic [LevelW-1:0] detect_threshold;
    logic [LevelW-1:0] trim_threshold;
    logic [MsW-1:0]    hold_delay_ms;
    logic [MsW-1:0]    gap_timeout_ms;
    logic [MsW-1:0]    rise_deadline_ms;
    logic [MsW-1:0]    rise_debounce_ms;
  } ppgd_cfg_t;

  typedef struct packed {
    ppgd_state_e      state;
    logic [TimeW-1:0] rise_time;
    logic [TimeW-1:0] fall_time;
  } ppgd_ctx_t;

  typedef struct packed {
    logic              click;
    logic              double_click;
    logic              stop;
    logic [PhaseW-1:0] phase;
  } ppgd_res_t;

  // one-hot state to reported phase code
  function automatic logic [PhaseW-1:0] phase_code(ppgd_state_e st);
    logic [PhaseW-1:0] code;
    case (st)
      ST_IDLE:   code = PHASE_IDLE;
      ST_FIRST:  code = PHASE_FIRST;
      ST_GAP:    code = PHASE_GAP;
      ST_SECOND: code = PHASE_SECOND;
      default:   code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: design/ppgd_in_if.sv
// request channel carrying one pedal sample and its timestamp
interface ppgd_in_if;
  logic                            valid;
  logic                            ready;
  logic [ppgd_pkg::LevelW-1:0]     sample_level;
  logic [ppgd_pkg::TimeW-1:0]      time_ms;

  modport source (output valid, output sample_level, output time_ms, input ready);
  modport sink   (input valid, input sample_level, input time_ms, output ready);
endinterface

FILE: design/ppgd_out_if.sv
// result channel carrying the gesture flags and the phase
interface ppgd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            click;
  logic                            double_click;
  logic                            stop;
  logic [ppgd_pkg::PhaseW-1:0]     phase;

  modport source (output valid, output click, output double_click, output stop,
                  output phase, input ready);
  modport sink   (input valid, input click, input double_click, input stop,
                  input phase, output ready);
endinterface

FILE: design/ppgd_step.sv
// next-state and result logic for one pedal sample
module ppgd_step (
  input  ppgd_pkg::ppgd_cfg_t            cfg_i,
  input  ppgd_pkg::ppgd_ctx_t            ctx_i,
  input  logic [ppgd_pkg::LevelW-1:0]    level_i,
  input  logic [ppgd_pkg::TimeW-1:0]     now_i,
  output ppgd_pkg::ppgd_ctx_t            ctx_o,
  output ppgd_pkg::ppgd_res_t            res_o
);

  logic [ppgd_pkg::TimeW-1:0] since_rise;
  logic [ppgd_pkg::TimeW-1:0] since_fall;
  logic                       above_detect;
  logic                       below_detect;
  logic                       above_trim;

  // elapsed times wrap modulo 2^32
  assign since_rise   = now_i - ctx_i.rise_time;
  assign since_fall   = now_i - ctx_i.fall_time;
  assign above_detect = level_i > cfg_i.detect_threshold;
  assign below_detect = level_i < cfg_i.detect_threshold;
  assign above_trim   = level_i > cfg_i.trim_threshold;

  // gesture state machine
  always_comb begin
    ctx_o              = ctx_i;
    res_o.click        = 1'b0;
    res_o.double_click = 1'b0;
    res_o.stop         = 1'b0;
    case (ctx_i.state)
      ppgd_pkg::ST_IDLE: begin
        if (above_detect) begin
          ctx_o.rise_time = now_i;
          ctx_o.state     = ppgd_pkg::ST_FIRST;
        end
      end
      ppgd_pkg::ST_FIRST: begin
        if (below_detect) begin
          ctx_o.fall_time = now_i;
          ctx_o.state     = ppgd_pkg::ST_GAP;
        end
        // hold check still runs on the falling sample
        res_o.click = since_rise > {{(ppgd_pkg::TimeW-ppgd_pkg::MsW){1'b0}},
                                    cfg_i.hold_delay_ms};
      end
      ppgd_pkg::ST_GAP: begin
        if (above_detect) begin
          ctx_o.rise_time = now_i;
          ctx_o.state     = ppgd_pkg::ST_SECOND;
        end
        // timeout wins over a rise on the same sample
        if (since_fall > {{(ppgd_pkg::TimeW-ppgd_pkg::MsW){1'b0}},
                          cfg_i.gap_timeout_ms}) begin
          ctx_o.state = ppgd_pkg::ST_IDLE;
          res_o.stop  = 1'b1;
        end
      end
      ppgd_pkg::ST_SECOND: begin
        if (above_trim
            && since_rise < {{(ppgd_pkg::TimeW-ppgd_pkg::MsW){1'b0}},
                             cfg_i.rise_deadline_ms}
            && since_rise > {{(ppgd_pkg::TimeW-ppgd_pkg::MsW){1'b0}},
                             cfg_i.rise_debounce_ms}) begin
          res_o.double_click = 1'b1;
        end
        if (below_detect) begin
          ctx_o.state = ppgd_pkg::ST_IDLE;
          res_o.stop  = 1'b1;
        end
      end
      default: begin
        ctx_o.state = ppgd_pkg::ST_IDLE;
      end
    endcase
    res_o.phase = ppgd_pkg::phase_code(ctx_o.state);
  end

endmodule

FILE: design/pedal_pulse_gesture_detector_core.sv
// Pedal pulse gesture detector: takes one sample per cycle (level and ms timestamp)
// and returns one result per sample with click, double_click, stop and the phase
// after that sample. The sample is captured in an input register; the gesture
// state machine and the timestamp compares then update the state and load the
// result register once it is free or being drained. Throughput is one sample per
// cycle while the result side keeps up; a held result stalls the input register,
// which still takes one more sample. Configuration writes are registered and
// are meant to happen only while no sample is in flight.
module pedal_pulse_gesture_detector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppgd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ppgd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  ppgd_in_if.sink                          req_i,
  ppgd_out_if.source                       res_o
);

  ppgd_pkg::ppgd_cfg_t         cfg_q;
  ppgd_pkg::ppgd_ctx_t         ctx_q;
  ppgd_pkg::ppgd_ctx_t         ctx_d;
  ppgd_pkg::ppgd_res_t         res_q;
  ppgd_pkg::ppgd_res_t         res_d;
  logic                        in_valid_q;
  logic [ppgd_pkg::LevelW-1:0] level_q;
  logic [ppgd_pkg::TimeW-1:0]  time_q;
  logic                        out_valid_q;
  logic                        advance;
  logic                        in_fire;

  // a captured sample moves on when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_fire     = req_i.valid && req_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_threshold <= ppgd_pkg::DetectThrRst;
      cfg_q.trim_threshold   <= ppgd_pkg::TrimThrRst;
      cfg_q.hold_delay_ms    <= ppgd_pkg::HoldDelayRst;
      cfg_q.gap_timeout_ms   <= ppgd_pkg::GapTimeoutRst;
      cfg_q.rise_deadline_ms <= ppgd_pkg::RiseDeadlnRst;
      cfg_q.rise_debounce_ms <= ppgd_pkg::RiseDebncRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppgd_pkg::CFG_DETECT_THR:  cfg_q.detect_threshold <= cfg_wdata_i[ppgd_pkg::LevelW-1:0];
        ppgd_pkg::CFG_TRIM_THR:    cfg_q.trim_threshold   <= cfg_wdata_i[ppgd_pkg::LevelW-1:0];
        ppgd_pkg::CFG_HOLD_DELAY:  cfg_q.hold_delay_ms    <= cfg_wdata_i[ppgd_pkg::MsW-1:0];
        ppgd_pkg::CFG_GAP_TIMEOUT: cfg_q.gap_timeout_ms   <= cfg_wdata_i[ppgd_pkg::MsW-1:0];
        ppgd_pkg::CFG_RISE_DEADLN: cfg_q.rise_deadline_ms <= cfg_wdata_i[ppgd_pkg::MsW-1:0];
        ppgd_pkg::CFG_RISE_DEBNC:  cfg_q.rise_debounce_ms <= cfg_wdata_i[ppgd_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q <= req_i.sample_level;
      time_q  <= req_i.time_ms;
    end
  end

  ppgd_step u_step (
    .cfg_i   (cfg_q),
    .ctx_i   (ctx_q),
    .level_i (level_q),
    .now_i   (time_q),
    .ctx_o   (ctx_d),
    .res_o   (res_d)
  );

  // gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state     <= ppgd_pkg::ST_IDLE;
      ctx_q.rise_time <= '0;
      ctx_q.fall_time <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.click        = res_q.click;
  assign res_o.double_click = res_q.double_click;
  assign res_o.stop         = res_q.stop;
  assign res_o.phase        = res_q.phase;

endmodule

FILE: test/pedal_pulse_gesture_detector_core_test.sv
// self-checking testbench for the pedal pulse gesture detector core
module pedal_pulse_gesture_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppgd_pkg::*;

  localparam int unsigned Latency        = 2;
  localparam int unsigned IdleLimit      = 1000;
  localparam int unsigned StallAt        = 200;
  localparam int unsigned StallCycles    = 60;
  localparam int unsigned NumProfiles    = 6;
  localparam int unsigned ProfileItems   = 76;
  localparam int unsigned DeadBandItems  = 20;

  // register indexes past the end of the register list
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    logic [LevelW-1:0]   level;
    logic [TimeW-1:0]    stamp;
    bit                  typed;
    ppgd_res_t           want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ppgd_in_if  req_if ();
  ppgd_out_if res_if ();

  pedal_pulse_gesture_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // gesture model state and its copy of the registers
  ppgd_cfg_t         cfg_mdl;
  logic [PhaseW-1:0] mdl_phase;
  logic [TimeW-1:0]  mdl_rise;
  logic [TimeW-1:0]  mdl_fall;
  logic [TimeW-1:0]  now_ms;

  ppgd_res_t   pending_res[$];
  dir_row_t    dir_rows[$];
  int unsigned sent_cnt;
  int unsigned res_cnt;
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the gesture model by one sample and return the flags it raises
  function automatic ppgd_res_t gesture_step(logic [LevelW-1:0] lvl, logic [TimeW-1:0] now);
    ppgd_res_t        r;
    logic [TimeW-1:0] d;
    r = '0;
    case (mdl_phase)
      PHASE_IDLE: begin
        if (lvl > cfg_mdl.detect_threshold) begin
          mdl_rise  = now;
          mdl_phase = PHASE_FIRST;
        end
      end
      PHASE_FIRST: begin
        if (lvl < cfg_mdl.detect_threshold) begin
          mdl_fall  = now;
          mdl_phase = PHASE_GAP;
        end
        d = now - mdl_rise;
        if (d > {16'd0, cfg_mdl.hold_delay_ms}) r.click = 1'b1;
      end
      PHASE_GAP: begin
        if (lvl > cfg_mdl.detect_threshold) begin
          mdl_rise  = now;
          mdl_phase = PHASE_SECOND;
        end
        // timeout wins over a rise on the same sample
        d = now - mdl_fall;
        if (d > {16'd0, cfg_mdl.gap_timeout_ms}) begin
          mdl_phase = PHASE_IDLE;
          r.stop    = 1'b1;
        end
      end
      default: begin
        if (lvl > cfg_mdl.trim_threshold) begin
          d = now - mdl_rise;
          if (d < {16'd0, cfg_mdl.rise_deadline_ms} && d > {16'd0, cfg_mdl.rise_debounce_ms})
            r.double_click = 1'b1;
        end
        if (lvl < cfg_mdl.detect_threshold) begin
          mdl_phase = PHASE_IDLE;
          r.stop    = 1'b1;
        end
      end
    endcase
    r.phase = mdl_phase;
    return r;
  endfunction

  // directed table entries
  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    dir_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_smp(logic [LevelW-1:0] lvl, logic [TimeW-1:0] stamp);
    dir_row_t row;
    row       = '{default: '0};
    row.level = lvl;
    row.stamp = stamp;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_exp(logic [LevelW-1:0] lvl, logic [TimeW-1:0] stamp,
                                  logic c, logic dc, logic s, logic [PhaseW-1:0] ph);
    dir_row_t row;
    row       = '{default: '0};
    row.level = lvl;
    row.stamp = stamp;
    row.typed = 1'b1;
    row.want  = '{click: c, double_click: dc, stop: s, phase: ph};
    dir_rows.push_back(row);
  endfunction

  // every third run of 32 requests goes without idling
  function automatic int unsigned draw_wait(int unsigned seq);
    return ((seq / 32) % 3 == 2) ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [LevelW-1:0] above_lvl(logic [LevelW-1:0] thr);
    return (thr == 10'd1023) ? thr : LevelW'($urandom_range(int'(thr) + 1, 1023));
  endfunction

  function automatic logic [LevelW-1:0] below_lvl(logic [LevelW-1:0] thr);
    return (thr == 10'd0) ? thr : LevelW'($urandom_range(0, int'(thr) - 1));
  endfunction

  // level biased toward the next move of the gesture machine, with some noise
  function automatic logic [LevelW-1:0] pick_level();
    int unsigned       r;
    logic [LevelW-1:0] det;
    r   = $urandom_range(0, 9);
    det = cfg_mdl.detect_threshold;
    if (r == 0) return LevelW'($urandom_range(0, 1023));
    if (r == 1) return det;
    case (mdl_phase)
      PHASE_IDLE:  return (r < 7) ? above_lvl(det) : below_lvl(det);
      PHASE_FIRST: return (r < 8) ? above_lvl(det) : below_lvl(det);
      PHASE_GAP:   return (r < 6) ? above_lvl(det) : below_lvl(det);
      default: begin
        if (r < 5) return above_lvl(cfg_mdl.trim_threshold);
        return (r < 7) ? above_lvl(det) : below_lvl(det);
      end
    endcase
  endfunction

  // timestamp: small steps, hits around the time limits, long jumps
  function automatic logic [TimeW-1:0] pick_stamp();
    int unsigned      r;
    logic [TimeW-1:0] k;
    r = $urandom_range(0, 9);
    k = TimeW'($urandom_range(0, 2)) - 32'd1;
    if (r < 4 || (r < 7 && mdl_phase == PHASE_IDLE)) begin
      now_ms = now_ms + $urandom_range(0, 3);
    end else if (r < 7) begin
      case (mdl_phase)
        PHASE_FIRST: now_ms = mdl_rise + cfg_mdl.hold_delay_ms + k;
        PHASE_GAP:   now_ms = mdl_fall + cfg_mdl.gap_timeout_ms + k;
        default: begin
          if ($urandom_range(0, 1) == 0) now_ms = mdl_rise + cfg_mdl.rise_deadline_ms + k;
          else now_ms = mdl_rise + cfg_mdl.rise_debounce_ms + k;
        end
      endcase
    end else if (r < 9) begin
      now_ms = now_ms + $urandom_range(0, 400);
    end else begin
      now_ms = $urandom;
    end
    return now_ms;
  endfunction

  // offer one sample, predict its result once it is taken
  task automatic send_sample(logic [LevelW-1:0] lvl, logic [TimeW-1:0] stamp,
                             bit typed, ppgd_res_t want);
    ppgd_res_t pred;
    repeat (draw_wait(sent_cnt)) @(negedge clk_i) req_if.valid <= 1'b0;
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.sample_level <= lvl;
    req_if.time_ms      <= stamp;
    do @(posedge clk_i); while (!req_if.ready);
    pred = gesture_step(lvl, stamp);
    pending_res.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i) req_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_DETECT_THR:  cfg_mdl.detect_threshold = val[LevelW-1:0];
      CFG_TRIM_THR:    cfg_mdl.trim_threshold   = val[LevelW-1:0];
      CFG_HOLD_DELAY:  cfg_mdl.hold_delay_ms    = val;
      CFG_GAP_TIMEOUT: cfg_mdl.gap_timeout_ms   = val;
      CFG_RISE_DEADLN: cfg_mdl.rise_deadline_ms = val;
      CFG_RISE_DEBNC:  cfg_mdl.rise_debounce_ms = val;
      default: ;
    endcase
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // register settings for each random phase, extremes first
  task automatic load_profile(int unsigned p);
    logic [CfgDataW-1:0] det, trim, hold, gap, dead, deb;
    case (p)
      0: begin
        det = '0; trim = '0; hold = '0; gap = '0; dead = '0; deb = '0;
      end
      1: begin
        det = '1; trim = '1; hold = '1; gap = '1; dead = '1; deb = '1;
      end
      2: begin
        det = 16'd512; trim = 16'd1023; hold = '1; gap = '1; dead = '1; deb = 16'hFFFE;
      end
      3: begin
        det  = CfgDataW'($urandom_range(1, 1022));
        trim = CfgDataW'($urandom_range(0, int'(det) - 1));
        hold = CfgDataW'($urandom_range(0, 300));
        gap  = CfgDataW'($urandom_range(0, 300));
        dead = CfgDataW'($urandom_range(0, 300));
        deb  = CfgDataW'($urandom_range(0, 50));
      end
      default: begin
        det  = CfgDataW'($urandom);
        trim = CfgDataW'($urandom);
        hold = CfgDataW'($urandom);
        gap  = CfgDataW'($urandom);
        dead = CfgDataW'($urandom);
        deb  = CfgDataW'($urandom);
      end
    endcase
    cfg_write(CFG_DETECT_THR, det);
    cfg_write(CFG_TRIM_THR, trim);
    cfg_write(CFG_HOLD_DELAY, hold);
    cfg_write(CFG_GAP_TIMEOUT, gap);
    cfg_write(CFG_RISE_DEADLN, dead);
    cfg_write(CFG_RISE_DEBNC, deb);
  endtask

  task automatic check_result(ppgd_res_t want);
    if (res_if.click !== want.click) begin
      $error("click: expected %0d, got %0d", want.click, res_if.click);
      mismatch_cnt++;
    end
    if (res_if.double_click !== want.double_click) begin
      $error("double_click: expected %0d, got %0d", want.double_click, res_if.double_click);
      mismatch_cnt++;
    end
    if (res_if.stop !== want.stop) begin
      $error("stop: expected %0d, got %0d", want.stop, res_if.stop);
      mismatch_cnt++;
    end
    if (res_if.phase !== want.phase) begin
      $error("phase: expected %0d, got %0d", want.phase, res_if.phase);
      mismatch_cnt++;
    end
  endtask

  // result side: random hold-offs, one long stall, in-order compare
  initial begin
    int unsigned hold;
    bit          stalled;
    stalled      = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (res_cnt == StallAt && !stalled) begin
        hold    = StallCycles;
        stalled = 1'b1;
      end else begin
        hold = draw_wait(res_cnt);
      end
      repeat (hold) @(negedge clk_i) res_if.ready <= 1'b0;
      @(negedge clk_i) res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (pending_res.size() == 0) begin
        $error("unexpected result: no prediction pending");
        mismatch_cnt++;
      end else begin
        check_result(pending_res.pop_front());
      end
      res_cnt++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("pedal_pulse_gesture_detector_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence: reset, directed table, random phases, drain
  initial begin
    dir_row_t    row;
    int unsigned n;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_DETECT_THR;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.sample_level = '0;
    req_if.time_ms      = '0;
    sent_cnt            = 0;
    res_cnt             = 0;
    mismatch_cnt        = 0;
    idle_cycles         = 0;
    cfg_mdl = '{detect_threshold: DetectThrRst, trim_threshold: TrimThrRst,
                hold_delay_ms: HoldDelayRst, gap_timeout_ms: GapTimeoutRst,
                rise_deadline_ms: RiseDeadlnRst, rise_debounce_ms: RiseDebncRst};
    mdl_phase = PHASE_IDLE;
    mdl_rise  = '0;
    mdl_fall  = '0;

    // reset values: idle, level equal to detect holds the phase
    add_exp(10'd0, 32'd0, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
    add_exp(10'd100, 32'd1, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
    add_exp(10'd1023, 32'd10, 1'b0, 1'b0, 1'b0, PHASE_FIRST);
    // held past the delay, then click together with the fall
    add_exp(10'd100, 32'd300, 1'b1, 1'b0, 1'b0, PHASE_FIRST);
    add_exp(10'd0, 32'd400, 1'b1, 1'b0, 1'b0, PHASE_GAP);
    add_smp(10'd50, 32'd500);
    add_smp(10'd1023, 32'd550);
    add_exp(10'd1023, 32'd600, 1'b0, 1'b1, 1'b0, PHASE_SECOND);
    add_exp(10'd0, 32'd760, 1'b0, 1'b0, 1'b1, PHASE_IDLE);
    // rise and gap timeout on the same sample
    add_smp(10'd500, 32'd1000);
    add_smp(10'd0, 32'd1001);
    add_exp(10'd600, 32'd1202, 1'b0, 1'b0, 1'b1, PHASE_IDLE);
    // plain gap timeout
    add_smp(10'd200, 32'd1300);
    add_smp(10'd0, 32'd1300);
    add_exp(10'd0, 32'd1501, 1'b0, 1'b0, 1'b1, PHASE_IDLE);
    // timestamps wrapping through zero, zero rise time inside the debounce
    add_smp(10'd1023, 32'hFFFF_FFF0);
    add_exp(10'd0, 32'h0000_00D9, 1'b1, 1'b0, 1'b0, PHASE_GAP);
    add_smp(10'd1023, 32'h0000_00E0);
    add_exp(10'd1023, 32'h0000_00E0, 1'b0, 1'b0, 1'b0, PHASE_SECOND);
    add_smp(10'd0, 32'h0000_00E1);
    // trim below detect: double_click and stop together
    add_cfg(CFG_TRIM_THR, 16'd50);
    add_smp(10'd500, 32'd2000);
    add_smp(10'd0, 32'd2001);
    add_smp(10'd500, 32'd2002);
    add_exp(10'd70, 32'd2005, 1'b0, 1'b1, 1'b1, PHASE_IDLE);
    // writes past the list are dropped, wide values are masked
    add_cfg(CFG_UNUSED_LO, 16'hFFFF);
    add_cfg(CFG_UNUSED_HI, 16'h0000);
    add_cfg(CFG_DETECT_THR, 16'hFFFF);
    add_exp(10'd1023, 32'd3000, 1'b0, 1'b0, 1'b0, PHASE_IDLE);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        settle();
        cfg_write(row.idx, row.wdata);
      end else begin
        send_sample(row.level, row.stamp, row.typed, row.want);
      end
    end

    for (int unsigned p = 0; p < NumProfiles; p++) begin
      settle();
      load_profile(p);
      now_ms = $urandom;
      n = (p == 1) ? DeadBandItems : ProfileItems;
      repeat (n) send_sample(pick_level(), pick_stamp(), 1'b0, '0);
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("pedal_pulse_gesture_detector_core verification clean");
    end else begin
      $display("pedal_pulse_gesture_detector_core verification failed");
    end
    $finish;
  end

endmodule
